@@ rtl/eamc_pkg.sv @@
// Package for the edge-avoid mode controller.
// Holds mode and state codes, register indexes, config and control structs, duty constants.
// No dependencies.
package eamc_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int DIST_W        = 10;
  localparam int CFG_TIME_W    = 16;
  localparam int PERIOD_W      = CFG_TIME_W + 1;
  localparam int DUTY_W        = 8;
  localparam int COUNT_W       = 5;
  localparam int SWAY_W        = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int OUT_W         = 24;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_ATTACK  = 3'd1,
    MODE_DEFENCE = 3'd2,
    MODE_SEARCH  = 3'd3,
    MODE_SPIN    = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_DISTANCE = 3'd0,
    CFG_FAR_DISTANCE    = 3'd1,
    CFG_TURN_TIME       = 3'd2,
    CFG_PAUSE_TIME      = 3'd3,
    CFG_COOLDOWN_TIME   = 3'd4,
    CFG_SWAY_CYCLES     = 3'd5,
    CFG_MINIMUM_DUTY    = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic [DIST_W-1:0]     attack_distance;
    logic [DIST_W-1:0]     far_distance;
    logic [CFG_TIME_W-1:0] turn_time;
    logic [CFG_TIME_W-1:0] pause_time;
    logic [CFG_TIME_W-1:0] cooldown_time;
    logic [SWAY_W-1:0]     sway_cycles;
    logic [DUTY_W-1:0]     minimum_duty;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

  localparam logic [DIST_W-1:0]     RST_ATTACK_DISTANCE = 10'd800;
  localparam logic [DIST_W-1:0]     RST_FAR_DISTANCE    = 10'd880;
  localparam logic [CFG_TIME_W-1:0] RST_TURN_TIME       = 16'd450;
  localparam logic [CFG_TIME_W-1:0] RST_PAUSE_TIME      = 16'd100;
  localparam logic [CFG_TIME_W-1:0] RST_COOLDOWN_TIME   = 16'd1000;
  localparam logic [SWAY_W-1:0]     RST_SWAY_CYCLES     = 4'd1;
  localparam logic [DUTY_W-1:0]     RST_MINIMUM_DUTY    = 8'd80;

  localparam logic [DUTY_W-1:0] DUTY_ATTACK_L = 8'd230;
  localparam logic [DUTY_W-1:0] DUTY_ATTACK_R = 8'd250;
  localparam logic [DUTY_W-1:0] DUTY_FULL     = 8'd255;
  localparam logic [DUTY_W-1:0] DUTY_SOFT     = 8'd170;
  localparam logic [DUTY_W-1:0] DUTY_HARD     = 8'd250;
  localparam logic [DUTY_W-1:0] DUTY_TURN_L   = 8'd200;
  localparam logic [DUTY_W-1:0] DUTY_TURN_R   = 8'd230;

  function automatic logic [DUTY_W-1:0] raise_duty(input logic [DUTY_W-1:0] d,
                                                   input logic [DUTY_W-1:0] min_d);
    logic [DUTY_W-1:0] r;
    r = d;
    if (d != '0 && d < min_d) r = min_d;
    return r;
  endfunction

endpackage

@@ rtl/eamc_ctrl.sv @@
// Sequencer for the edge-avoid mode controller: load, divide, commit.
// Drives the input ready and output valid. Depends on eamc_pkg.
module eamc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output eamc_pkg::cmd_t cmd,
  input  eamc_pkg::sts_t sts
);

  eamc_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= eamc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      eamc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = eamc_pkg::ST_DIV;
        end
      end
      eamc_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) state_nxt = eamc_pkg::ST_DONE;
      end
      eamc_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = eamc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = eamc_pkg::ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

@@ rtl/eamc_dp.sv @@
// Datapath for the edge-avoid mode controller: item latch, serial sway-phase divider,
// mode, escape and sway state, motor drive. Depends on eamc_pkg.
module eamc_dp #(
  parameter int TIME_BITS = eamc_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  eamc_pkg::cmd_t                cmd,
  output eamc_pkg::sts_t                sts,
  input  eamc_pkg::cfg_t                cfg,
  input  logic [TIME_BITS-1:0]          in_now_ms,
  input  logic [4:0]                    in_edges,
  input  logic [eamc_pkg::DIST_W-1:0]   in_distance,
  input  logic                          in_start,
  output eamc_pkg::mode_t               mode_now,
  output logic                          left_reverse,
  output logic [eamc_pkg::DUTY_W-1:0]   left_duty,
  output logic                          right_reverse,
  output logic [eamc_pkg::DUTY_W-1:0]   right_duty
);

  localparam int CNT_W = (TIME_BITS > 1) ? $clog2(TIME_BITS) : 1;
  localparam int PW    = eamc_pkg::PERIOD_W;
  localparam int DW    = eamc_pkg::DUTY_W;
  localparam int CW    = eamc_pkg::COUNT_W;

  // latched item
  logic [TIME_BITS-1:0]        now_r;
  logic [4:0]                  edges_r;
  logic [eamc_pkg::DIST_W-1:0] dist_r;
  logic                        start_r;
  logic                        far_r;
  logic [TIME_BITS-1:0]        e_r;

  // divider
  logic [TIME_BITS-1:0] dvd_r;
  logic [PW-1:0]        rem_r;
  logic                 qbit_r;
  logic [CNT_W-1:0]     cnt_r;

  // controller state
  eamc_pkg::mode_t      mode_r, mode_nxt;
  logic                 esc_done_r, esc_done_nxt;
  logic [TIME_BITS-1:0] esc_time_r, esc_time_nxt;
  logic [TIME_BITS-1:0] sway_start_r, sway_start_nxt;
  logic                 sway_right_r, sway_right_nxt;
  logic [CW-1:0]        sway_count_r, sway_count_nxt;
  logic                 dir_l_r, dir_l_nxt, dir_r_r, dir_r_nxt;
  logic [DW-1:0]        duty_l_r, duty_l_nxt, duty_r_r, duty_r_nxt;

  logic [PW-1:0] period;
  logic [PW:0]   rem_sh;
  logic          rem_ge;
  logic          any_edge_in, far_in;
  logic [TIME_BITS-1:0] esc_elapsed;
  logic          any_edge, cool_ok, done_eff, right_eff, odd_phase;
  logic [CW-1:0] count_eff;
  logic [DW-1:0] duty_l_raw, duty_r_raw;

  assign period      = {1'b0, cfg.turn_time} + {1'b0, cfg.pause_time};
  assign any_edge_in = |in_edges;
  assign far_in      = (mode_r != eamc_pkg::MODE_IDLE) && !any_edge_in &&
                       (in_distance >= cfg.far_distance);

  assign rem_sh = {rem_r, dvd_r[TIME_BITS-1]};
  assign rem_ge = rem_sh >= {1'b0, period};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r   <= in_now_ms;
      edges_r <= in_edges;
      dist_r  <= in_distance;
      start_r <= in_start;
      far_r   <= far_in;
      e_r     <= far_in ? '0 : in_now_ms - sway_start_r;
      dvd_r   <= far_in ? '0 : in_now_ms - sway_start_r;
      rem_r   <= '0;
      qbit_r  <= 1'b0;
      cnt_r   <= CNT_W'(TIME_BITS - 1);
    end else if (cmd.step) begin
      dvd_r  <= dvd_r << 1;
      rem_r  <= rem_ge ? PW'(rem_sh - {1'b0, period}) : PW'(rem_sh);
      qbit_r <= rem_ge;
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign sts.div_last = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= eamc_pkg::MODE_IDLE;
      esc_done_r   <= 1'b1;
      esc_time_r   <= '0;
      sway_start_r <= '0;
      sway_right_r <= 1'b0;
      sway_count_r <= '0;
      dir_l_r      <= 1'b0;
      dir_r_r      <= 1'b0;
      duty_l_r     <= '0;
      duty_r_r     <= '0;
    end else if (cmd.commit) begin
      mode_r       <= mode_nxt;
      esc_done_r   <= esc_done_nxt;
      esc_time_r   <= esc_time_nxt;
      sway_start_r <= sway_start_nxt;
      sway_right_r <= sway_right_nxt;
      sway_count_r <= sway_count_nxt;
      dir_l_r      <= dir_l_nxt;
      dir_r_r      <= dir_r_nxt;
      duty_l_r     <= duty_l_nxt;
      duty_r_r     <= duty_r_nxt;
    end
  end

  assign any_edge    = |edges_r;
  assign esc_elapsed = now_r - esc_time_r;
  assign cool_ok     = (TIME_BITS + 1)'(esc_elapsed) >= (TIME_BITS + 1)'(cfg.cooldown_time);
  assign done_eff    = esc_done_r && !cool_ok;
  assign right_eff   = far_r ? 1'b0 : sway_right_r;
  assign count_eff   = far_r ? '0 : sway_count_r;
  assign odd_phase   = (period != '0) && qbit_r;

  always_comb begin
    mode_nxt       = mode_r;
    esc_done_nxt   = esc_done_r;
    esc_time_nxt   = esc_time_r;
    sway_start_nxt = sway_start_r;
    sway_right_nxt = sway_right_r;
    sway_count_nxt = sway_count_r;
    dir_l_nxt      = dir_l_r;
    dir_r_nxt      = dir_r_r;
    duty_l_raw     = duty_l_r;
    duty_r_raw     = duty_r_r;
    duty_l_nxt     = duty_l_r;
    duty_r_nxt     = duty_r_r;
    if (mode_r == eamc_pkg::MODE_IDLE) begin
      duty_l_nxt = '0;
      duty_r_nxt = '0;
      if (start_r) begin
        mode_nxt       = eamc_pkg::MODE_SEARCH;
        sway_start_nxt = now_r;
        sway_right_nxt = 1'b0;
        sway_count_nxt = '0;
      end
    end else begin
      if (any_edge) begin
        mode_nxt = eamc_pkg::MODE_DEFENCE;
        if (!done_eff) begin
          esc_time_nxt = now_r;
          esc_done_nxt = 1'b1;
          if (edges_r[2] && edges_r[3]) begin
            {dir_l_nxt, dir_r_nxt} = 2'b00;
            duty_l_raw = eamc_pkg::DUTY_FULL;
            duty_r_raw = eamc_pkg::DUTY_FULL;
          end else if (edges_r[0]) begin
            {dir_l_nxt, dir_r_nxt} = 2'b11;
            duty_l_raw = eamc_pkg::DUTY_FULL;
            duty_r_raw = eamc_pkg::DUTY_FULL;
          end else if (edges_r[1]) begin
            {dir_l_nxt, dir_r_nxt} = 2'b00;
            duty_l_raw = eamc_pkg::DUTY_SOFT;
            duty_r_raw = eamc_pkg::DUTY_HARD;
          end else if (edges_r[4]) begin
            {dir_l_nxt, dir_r_nxt} = 2'b00;
            duty_l_raw = eamc_pkg::DUTY_HARD;
            duty_r_raw = eamc_pkg::DUTY_SOFT;
          end else begin
            {dir_l_nxt, dir_r_nxt} = 2'b00;
            duty_l_raw = eamc_pkg::DUTY_HARD;
            duty_r_raw = eamc_pkg::DUTY_HARD;
          end
        end else begin
          esc_done_nxt = 1'b1;
        end
      end else if (!far_r && dist_r <= cfg.attack_distance) begin
        mode_nxt     = eamc_pkg::MODE_ATTACK;
        esc_done_nxt = 1'b0;
        if (dist_r < cfg.attack_distance) begin
          {dir_l_nxt, dir_r_nxt} = 2'b00;
          duty_l_raw = eamc_pkg::DUTY_ATTACK_L;
          duty_r_raw = eamc_pkg::DUTY_ATTACK_R;
        end
      end else begin
        mode_nxt       = eamc_pkg::MODE_SEARCH;
        sway_start_nxt = far_r ? now_r : sway_start_r;
        sway_right_nxt = right_eff;
        sway_count_nxt = count_eff;
        if (dist_r <= cfg.attack_distance) begin
          mode_nxt       = eamc_pkg::MODE_ATTACK;
          sway_count_nxt = '0;
        end else if (count_eff >= {cfg.sway_cycles, 1'b0}) begin
          mode_nxt       = eamc_pkg::MODE_SPIN;
          sway_count_nxt = '0;
        end else begin
          if (!odd_phase) begin
            dir_l_nxt  = !right_eff;
            dir_r_nxt  = right_eff;
            duty_l_raw = eamc_pkg::DUTY_TURN_L;
            duty_r_raw = eamc_pkg::DUTY_TURN_R;
          end else begin
            duty_l_raw = '0;
            duty_r_raw = '0;
          end
          if ((TIME_BITS + 1)'(e_r) >= (TIME_BITS + 1)'(period)) begin
            sway_start_nxt = now_r;
            sway_right_nxt = !right_eff;
            sway_count_nxt = count_eff + 1'b1;
          end
        end
      end
      duty_l_nxt = eamc_pkg::raise_duty(duty_l_raw, cfg.minimum_duty);
      duty_r_nxt = eamc_pkg::raise_duty(duty_r_raw, cfg.minimum_duty);
    end
  end

  assign mode_now      = mode_r;
  assign left_reverse  = dir_l_r;
  assign left_duty     = duty_l_r;
  assign right_reverse = dir_r_r;
  assign right_duty    = duty_r_r;

endmodule

@@ rtl/edge_avoid_mode_controller.sv @@
// Edge-avoid mode controller: one result item per input item.
// An accepted item is latched, divided serially by the sway divider, then committed;
// the commit waits while a result is stalled. One item is in work at a time; input is taken while a result waits.
// Reset (rst_n low, synchronous): idle mode, motors off, config at reset values.
// Config registers live here; sequencing in eamc_ctrl, state and divider in eamc_dp.
module edge_avoid_mode_controller #(
  parameter int TIME_BITS = eamc_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // now_ms, edge_front, edge_right, edge_back_right, edge_back_left, edge_left,
  // distance, start_pressed, zero pad
  input  logic [((TIME_BITS+16+7)/8)*8-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // mode_now, left_reverse, left_duty, right_reverse, right_duty, zero pad
  output logic [eamc_pkg::OUT_W-1:0]           out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [eamc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [eamc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  eamc_pkg::cfg_t  cfg_r;
  eamc_pkg::cmd_t  cmd;
  eamc_pkg::sts_t  sts;
  eamc_pkg::mode_t mode_now;
  logic            left_reverse, right_reverse;
  logic [eamc_pkg::DUTY_W-1:0] left_duty, right_duty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_distance <= eamc_pkg::RST_ATTACK_DISTANCE;
      cfg_r.far_distance    <= eamc_pkg::RST_FAR_DISTANCE;
      cfg_r.turn_time       <= eamc_pkg::RST_TURN_TIME;
      cfg_r.pause_time      <= eamc_pkg::RST_PAUSE_TIME;
      cfg_r.cooldown_time   <= eamc_pkg::RST_COOLDOWN_TIME;
      cfg_r.sway_cycles     <= eamc_pkg::RST_SWAY_CYCLES;
      cfg_r.minimum_duty    <= eamc_pkg::RST_MINIMUM_DUTY;
    end else if (cfg_valid) begin
      case (cfg_index)
        eamc_pkg::CFG_ATTACK_DISTANCE:
          cfg_r.attack_distance <= cfg_data[eamc_pkg::DIST_W-1:0];
        eamc_pkg::CFG_FAR_DISTANCE:
          cfg_r.far_distance <= cfg_data[eamc_pkg::DIST_W-1:0];
        eamc_pkg::CFG_TURN_TIME:     cfg_r.turn_time     <= cfg_data;
        eamc_pkg::CFG_PAUSE_TIME:    cfg_r.pause_time    <= cfg_data;
        eamc_pkg::CFG_COOLDOWN_TIME: cfg_r.cooldown_time <= cfg_data;
        eamc_pkg::CFG_SWAY_CYCLES:
          cfg_r.sway_cycles <= cfg_data[eamc_pkg::SWAY_W-1:0];
        eamc_pkg::CFG_MINIMUM_DUTY:
          cfg_r.minimum_duty <= cfg_data[eamc_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  eamc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  eamc_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg           (cfg_r),
    .in_now_ms     (in_tdata[TIME_BITS-1:0]),
    .in_edges      (in_tdata[TIME_BITS+4:TIME_BITS]),
    .in_distance   (in_tdata[TIME_BITS+14:TIME_BITS+5]),
    .in_start      (in_tdata[TIME_BITS+15]),
    .mode_now      (mode_now),
    .left_reverse  (left_reverse),
    .left_duty     (left_duty),
    .right_reverse (right_reverse),
    .right_duty    (right_duty)
  );

  assign out_tdata = {3'b000, right_duty, right_reverse, left_duty, left_reverse, mode_now};

endmodule

@@ rtl/eamc_checker.sv @@
// Port-level checker for the edge-avoid mode controller, bound to the top level.
// Depends on eamc_pkg and edge_avoid_mode_controller.
module eamc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [eamc_pkg::OUT_W-1:0]   out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  a_idle_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == eamc_pkg::MODE_IDLE |->
      out_tdata[11:4] == '0 && out_tdata[20:13] == '0)
    else $error("motor driven in idle mode");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind edge_avoid_mode_controller eamc_checker u_eamc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
